/* rtl/pressure_compensation_minmax_core_defines.svh */
// ----------------------------------------------------------------------------
// pressure_compensation_minmax_core_defines.svh
// Assertion macros used by the compensation core.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_COMPENSATION_MINMAX_CORE_DEFINES_SVH
`define PRESSURE_COMPENSATION_MINMAX_CORE_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define PCM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcm: same-cycle check failed");

// Next-cycle implication, idle during reset.
`define PCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcm: next-cycle check failed");

`endif

/* rtl/pcm_pkg.sv */
// ----------------------------------------------------------------------------
// pcm_pkg
// Types and constants of the pressure compensation core.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int SENSOR_COUNT_DEF = 8;
    localparam int SENSOR_W         = 3;
    localparam int WORD_W           = 16;
    localparam int RAW_SHIFT        = 6;
    localparam int VAL_W            = WORD_W - RAW_SHIFT;
    localparam int CROSS_W          = 14;

    localparam int COMP_W           = 14;
    localparam int KPA_W            = 11;

    // Shared multiplier: signed A times unsigned B
    localparam int MUL_A_W          = 25;
    localparam int MUL_B_W          = VAL_W;
    localparam int MUL_P_W          = MUL_A_W + MUL_B_W + 1;

    // Sum carries 22 fraction bits; output keeps 4
    localparam int ACC_W            = 38;
    localparam int FRAC_SHIFT       = 18;
    localparam int OFFSET_SHIFT     = 19;
    localparam int PGAIN_SHIFT      = 9;
    localparam int TGAIN_SHIFT      = 8;
    localparam int ROUND_BIT        = 17;

    // kPa conversion: x = comp*65, q = floor(x/1023)
    localparam int KPA_X_W          = 21;
    localparam int KPA_MUL_SHIFT    = 6;
    localparam int RECIP_SHIFT      = 10;
    localparam int RECIP_W          = KPA_X_W + RECIP_SHIFT;

    localparam logic [COMP_W-1:0]  COMP_MAX    = 14'd16383;
    localparam logic [COMP_W-1:0]  MIN_RESTART = 14'd16368;
    localparam logic [KPA_W-1:0]   KPA_BASE    = 11'd800;
    localparam logic [KPA_X_W-1:0] KPA_DIVISOR = 21'd1023;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [SENSOR_W-1:0]      sensor;
        logic                     first_of_round;
        logic [WORD_W-1:0]        pressure_word;
        logic [WORD_W-1:0]        temp_word;
        logic signed [WORD_W-1:0] coef_offset;
        logic signed [WORD_W-1:0] coef_pressure_gain;
        logic signed [WORD_W-1:0] coef_temp_gain;
        logic [WORD_W-1:0]        coef_cross_word;
    } t_in;

    typedef struct packed {
        logic [COMP_W-1:0] compensated;
        logic [KPA_W-1:0]  pressure_kpa;
        logic [COMP_W-1:0] min_compensated;
        logic [COMP_W-1:0] max_compensated;
    } t_out;

    typedef struct packed {
        logic signed [WORD_W-1:0]  a0;
        logic signed [WORD_W-1:0]  b1;
        logic signed [WORD_W-1:0]  b2;
        logic signed [CROSS_W-1:0] c12;
    } t_coef;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } t_mul_req;

endpackage

/* rtl/pcm_ram.sv */
// ----------------------------------------------------------------------------
// pcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pcm_mul.sv */
// ----------------------------------------------------------------------------
// pcm_mul
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pcm_mul (
    input  logic                                i_clk,
    input  pcm_pkg::t_mul_req                   i_req,
    output logic signed [pcm_pkg::MUL_P_W-1:0]  o_prod
);
    import pcm_pkg::*;

    logic signed [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * $signed({1'b0, i_req.b});
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/pressure_compensation_minmax_core.sv */
// ----------------------------------------------------------------------------
// pressure_compensation_minmax_core
// A sample runs through eight sequencer steps (four multiplier passes,
//   last add, rounding, kPa, finish) after its input transfer; output
//   valid is registered in finish, which holds while a previous result
//   waits. A coefficient load completes in the cycle of its transfer.
// Reset (synchronous, active low): sequencer idle, no pending output,
//   minimum at 1023.0, maximum at 0; coefficient RAM is not cleared.
// ----------------------------------------------------------------------------
`include "pressure_compensation_minmax_core_defines.svh"

module pressure_compensation_minmax_core #(
    parameter int SENSOR_COUNT = pcm_pkg::SENSOR_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pcm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pcm_pkg::t_out o_out_data
);
    import pcm_pkg::*;

    localparam int AW    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int EXT_W = (AW > SENSOR_W) ? AW : SENSOR_W;

    // One-hot sequencer: four multiplier passes, then add, round, kPa, finish
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL1  = 9'b000000010,
        S_MUL2  = 9'b000000100,
        S_MUL3  = 9'b000001000,
        S_MUL4  = 9'b000010000,
        S_ADD   = 9'b000100000,
        S_ROUND = 9'b001000000,
        S_KPA   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state                    r_state, n_state;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic [VAL_W-1:0]          r_p, n_p;
    logic [VAL_W-1:0]          r_t, n_t;
    logic                      r_first, n_first;
    logic [COMP_W-1:0]         r_comp, n_comp;
    logic [KPA_X_W-1:0]        r_x, n_x;
    logic [KPA_W-1:0]          r_q, n_q;
    logic [COMP_W-1:0]         r_min, n_min;
    logic [COMP_W-1:0]         r_max, n_max;
    logic                      r_out_valid, n_out_valid;
    t_out                      r_out, n_out;

    logic                      in_xfer;
    logic                      in_range;
    logic [EXT_W-1:0]          sensor_ext;
    logic [AW-1:0]             addr;
    logic                      ram_we;
    logic                      ram_re;
    t_coef                     wr_coef;
    t_coef                     coef;
    t_mul_req                  mul_req;
    logic signed [MUL_P_W-1:0] mul_prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [ACC_W-FRAC_SHIFT-1:0] q_full;
    logic [RECIP_W-1:0]        recip_sum;
    logic [KPA_X_W-1:0]        x_val;
    logic [KPA_X_W-1:0]        q_times_div;
    logic [KPA_X_W-1:0]        rem;
    logic [KPA_W-1:0]          q_fix;
    logic [COMP_W-1:0]         min_base;
    logic [COMP_W-1:0]         max_base;
    logic                      out_free;

    // ---------------- Input side ----------------
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign sensor_ext = EXT_W'(i_in_data.sensor);
    assign in_range   = (32'(i_in_data.sensor) < 32'(SENSOR_COUNT));
    assign addr       = sensor_ext[AW-1:0];

    // Load writes the entry; sample reads it for the next cycle
    assign ram_we = in_xfer && in_range && (i_in_data.kind == KIND_LOAD);
    assign ram_re = in_xfer && in_range && (i_in_data.kind == KIND_SAMPLE);

    // Cross coefficient: raw word arithmetic-shifted right by two
    assign wr_coef.a0  = i_in_data.coef_offset;
    assign wr_coef.b1  = i_in_data.coef_pressure_gain;
    assign wr_coef.b2  = i_in_data.coef_temp_gain;
    assign wr_coef.c12 = $signed(i_in_data.coef_cross_word[WORD_W-1:WORD_W-CROSS_W]);

    pcm_ram #(
        .WIDTH ($bits(t_coef)),
        .DEPTH (SENSOR_COUNT)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (wr_coef),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (coef)
    );

    pcm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // ---------------- Datapath helpers ----------------
    assign prod_ext = ACC_W'(mul_prod);
    assign q_full   = r_acc[ACC_W-1:FRAC_SHIFT];

    // comp*65, then reciprocal estimate x*1025 >> 20 (never above the true quotient)
    assign x_val     = {1'b0, r_comp, {KPA_MUL_SHIFT{1'b0}}} + KPA_X_W'(r_comp);
    assign recip_sum = {x_val, {RECIP_SHIFT{1'b0}}} + RECIP_W'(x_val);

    // Correct the estimate by at most one
    assign q_times_div = {r_q, {RECIP_SHIFT{1'b0}}} - KPA_X_W'(r_q);
    assign rem         = r_x - q_times_div;
    assign q_fix       = (rem >= KPA_DIVISOR) ? (r_q + KPA_W'(1)) : r_q;

    // First sample of a round restarts tracking before it is counted
    assign min_base = r_first ? MIN_RESTART : r_min;
    assign max_base = r_first ? '0 : r_max;

    assign out_free = !r_out_valid || i_out_ready;

    // ---------------- Sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_p         = r_p;
        n_t         = r_t;
        n_first     = r_first;
        n_comp      = r_comp;
        n_x         = r_x;
        n_q         = r_q;
        n_min       = r_min;
        n_max       = r_max;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mul_req     = '0;

        // Drop the output once the downstream side takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (ram_re) begin
                    n_p     = i_in_data.pressure_word[WORD_W-1:RAW_SHIFT];
                    n_t     = i_in_data.temp_word[WORD_W-1:RAW_SHIFT];
                    n_first = i_in_data.first_of_round;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                // c12*T; seed the sum with the offset and the rounding half
                mul_req = '{en: 1'b1, a: MUL_A_W'(coef.c12), b: r_t};
                n_acc   = (ACC_W'(coef.a0) <<< OFFSET_SHIFT)
                        + (ACC_W'(1) <<< ROUND_BIT);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                // (c12*T)*P
                mul_req = '{en: 1'b1, a: $signed(mul_prod[MUL_A_W-1:0]), b: r_p};
                n_state = S_MUL3;
            end
            S_MUL3: begin
                mul_req = '{en: 1'b1, a: MUL_A_W'(coef.b1), b: r_p};
                n_acc   = r_acc + prod_ext;
                n_state = S_MUL4;
            end
            S_MUL4: begin
                mul_req = '{en: 1'b1, a: MUL_A_W'(coef.b2), b: r_t};
                n_acc   = r_acc + (prod_ext <<< PGAIN_SHIFT);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_acc   = r_acc + (prod_ext <<< TGAIN_SHIFT);
                n_state = S_ROUND;
            end
            S_ROUND: begin
                // Floor to 4 fraction bits, clamp at both ends
                if (r_acc[ACC_W-1]) begin
                    n_comp = '0;
                end else if (q_full > (ACC_W-FRAC_SHIFT)'(COMP_MAX)) begin
                    n_comp = COMP_MAX;
                end else begin
                    n_comp = q_full[COMP_W-1:0];
                end
                n_state = S_KPA;
            end
            S_KPA: begin
                n_x     = x_val;
                n_q     = recip_sum[RECIP_W-1:RECIP_W-KPA_W];
                n_state = S_FIN;
            end
            S_FIN: begin
                // Hold here while the previous result still waits
                if (out_free) begin
                    n_min = (r_comp < min_base) ? r_comp : min_base;
                    n_max = (r_comp > max_base) ? r_comp : max_base;
                    n_out.compensated     = r_comp;
                    n_out.pressure_kpa    = q_fix + KPA_BASE;
                    n_out.min_compensated = (r_comp < min_base) ? r_comp : min_base;
                    n_out.max_compensated = (r_comp > max_base) ? r_comp : max_base;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_min       <= MIN_RESTART;
            r_max       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_min       <= n_min;
            r_max       <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_p     <= n_p;
        r_t     <= n_t;
        r_first <= n_first;
        r_comp  <= n_comp;
        r_x     <= n_x;
        r_q     <= n_q;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- Assertions ----------------
    `PCM_ASSERT_NEXT(a_sample_starts, ram_re, r_state == S_MUL1)
    `PCM_ASSERT_NEXT(a_fin_delivers, (r_state == S_FIN) && out_free, o_out_valid && o_in_ready)
    `PCM_ASSERT_SAME(a_minmax_order, o_out_valid, (o_out_data.min_compensated <= o_out_data.compensated) && (o_out_data.compensated <= o_out_data.max_compensated))
    `PCM_ASSERT_SAME(a_kpa_range, o_out_valid, (o_out_data.pressure_kpa >= 11'd800) && (o_out_data.pressure_kpa <= 11'd1840))

endmodule
